// ===== sv/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, sizes and helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // stream field widths
    localparam int OP_W       = 3;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 6;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_REAR  = 3'd0,
        OP_POP_REAR   = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_LIST       = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_LIST_RD,
        S_LIST_WAIT
    } t_state;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_ram_req;

    typedef struct packed {
        logic               load;
        logic [DATA_W-1:0]  value;
        t_status            status;
        logic [CNT_W-1:0]   count;
        logic               last;
    } t_res;

    // ring position at offset from front, offset below DEPTH
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] front,
                                              input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, front} + {1'b0, off};
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ===== sv/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: keeps front index and occupancy, drives the ring RAM and
// produces result words for the output register.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [deq_pkg::OP_W-1:0]     i_op,
    input  logic [deq_pkg::VALUE_W-1:0]  i_value,
    output logic                         o_ready,
    input  logic                         i_out_free,
    input  logic [deq_pkg::DATA_W-1:0]   i_rdata,
    output deq_pkg::t_ram_req            o_ram,
    output deq_pkg::t_res                o_res
);

    deq_pkg::t_state                r_state, n_state;
    logic [deq_pkg::IDX_W-1:0]      r_front, n_front;
    logic [deq_pkg::CNT_W-1:0]      r_occ,   n_occ;
    logic [deq_pkg::CNT_W-1:0]      r_idx,   n_idx;

    logic full;
    logic empty;
    logic list_last;

    assign full      = (r_occ == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign empty     = (r_occ == '0);
    assign list_last = ((r_idx + deq_pkg::CNT_W'(1)) == r_occ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::S_IDLE;
            r_front <= '0;
            r_occ   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_occ   <= n_occ;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_occ       = r_occ;
        n_idx       = r_idx;
        o_ready     = 1'b0;
        o_ram       = '0;
        o_ram.wdata = i_value[deq_pkg::DATA_W-1:0];
        o_res       = '0;
        o_res.status = deq_pkg::ST_OK;

        unique case (r_state)
            deq_pkg::S_IDLE: begin
                o_ready = i_out_free;
                if (i_valid && i_out_free) begin
                    unique case (deq_pkg::t_op'(i_op))
                        deq_pkg::OP_PUSH_REAR, deq_pkg::OP_PUSH_FRONT: begin
                            o_res.load = 1'b1;
                            o_res.last = 1'b1;
                            if (full) begin
                                o_res.status = deq_pkg::ST_FULL;
                                o_res.count  = r_occ;
                            end else begin
                                o_ram.we    = 1'b1;
                                n_occ       = r_occ + deq_pkg::CNT_W'(1);
                                o_res.count = n_occ;
                                if (deq_pkg::t_op'(i_op) == deq_pkg::OP_PUSH_REAR) begin
                                    o_ram.waddr = deq_pkg::slot(r_front, r_occ);
                                end else begin
                                    n_front = deq_pkg::slot(r_front,
                                        deq_pkg::CNT_W'(deq_pkg::DEPTH - 1));
                                    o_ram.waddr = n_front;
                                end
                            end
                        end
                        deq_pkg::OP_POP_REAR, deq_pkg::OP_POP_FRONT: begin
                            if (empty) begin
                                o_res.load   = 1'b1;
                                o_res.last   = 1'b1;
                                o_res.status = deq_pkg::ST_EMPTY;
                            end else begin
                                o_ram.re = 1'b1;
                                n_occ    = r_occ - deq_pkg::CNT_W'(1);
                                n_state  = deq_pkg::S_POP;
                                if (deq_pkg::t_op'(i_op) == deq_pkg::OP_POP_REAR) begin
                                    o_ram.raddr = deq_pkg::slot(r_front, n_occ);
                                end else begin
                                    o_ram.raddr = r_front;
                                    n_front = deq_pkg::slot(r_front, deq_pkg::CNT_W'(1));
                                end
                            end
                        end
                        deq_pkg::OP_LIST: begin
                            if (empty) begin
                                o_res.load   = 1'b1;
                                o_res.last   = 1'b1;
                                o_res.status = deq_pkg::ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = deq_pkg::S_LIST_RD;
                            end
                        end
                        default: begin
                            // unused code: drop the word
                        end
                    endcase
                end
            end
            deq_pkg::S_POP: begin
                // output register is free: it was free or draining at accept
                o_res.load  = 1'b1;
                o_res.value = i_rdata;
                o_res.count = r_occ;
                o_res.last  = 1'b1;
                n_state     = deq_pkg::S_IDLE;
            end
            deq_pkg::S_LIST_RD: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = deq_pkg::slot(r_front, r_idx);
                n_state     = deq_pkg::S_LIST_WAIT;
            end
            deq_pkg::S_LIST_WAIT: begin
                if (i_out_free) begin
                    o_res.load  = 1'b1;
                    o_res.value = i_rdata;
                    o_res.count = r_occ;
                    o_res.last  = list_last;
                    if (list_last) begin
                        n_state = deq_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + deq_pkg::CNT_W'(1);
                        n_state = deq_pkg::S_LIST_RD;
                    end
                end
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/double_ended_queue.sv =====
// A push result is registered at accept and shows in the cycle after; a
// popped or listed item passes the RAM read register, then the output register.
// Pushes go 1 word per cycle while the output is not stalled. The block
// takes no new word while a pop or listing is in flight.
// Reset (i_rst_n low, synchronous): queue empty, output word dropped;
// the ring RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue in a ring RAM with a registered output stage.
// ----------------------------------------------------------------------------
module double_ended_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [2:0] op, [34:3] push_value, [39:35] zero
    input  logic [deq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] item_value, [37:32] item_count, [39:38] zero
    output logic [deq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [1:0] status
    output logic [deq_pkg::STATUS_W-1:0]   m_axis_tuser,
    output logic                           m_axis_tlast
);

    deq_pkg::t_ram_req               ram;
    deq_pkg::t_res                   res;
    logic [deq_pkg::DATA_W-1:0]      rdata;
    logic                            out_free;

    logic                            r_out_valid;
    logic [deq_pkg::VALUE_W-1:0]     r_out_value;
    logic [deq_pkg::STATUS_W-1:0]    r_out_status;
    logic [deq_pkg::COUNT_W-1:0]     r_out_count;
    logic                            r_out_last;

    assign out_free = !r_out_valid || m_axis_tready;

    deq_ram #(
        .DEPTH (deq_pkg::DEPTH),
        .WIDTH (deq_pkg::DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram.we),
        .i_waddr (ram.waddr),
        .i_wdata (ram.wdata),
        .i_re    (ram.re),
        .i_raddr (ram.raddr),
        .o_rdata (rdata)
    );

    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_op       (s_axis_tdata[deq_pkg::OP_W-1:0]),
        .i_value    (s_axis_tdata[deq_pkg::OP_W +: deq_pkg::VALUE_W]),
        .o_ready    (s_axis_tready),
        .i_out_free (out_free),
        .i_rdata    (rdata),
        .o_ram      (ram),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_out_value  <= deq_pkg::VALUE_W'(res.value);
            r_out_status <= res.status;
            r_out_count  <= deq_pkg::COUNT_W'(res.count);
            r_out_last   <= res.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(deq_pkg::M_TDATA_W - deq_pkg::VALUE_W - deq_pkg::COUNT_W){1'b0}},
                            r_out_count, r_out_value};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== sv/deq_chk.sv =====
// ----------------------------------------------------------------------------
// deq_chk
// Port-level checks on the double-ended queue output stream.
// ----------------------------------------------------------------------------
module deq_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [deq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic [deq_pkg::STATUS_W-1:0]   m_axis_tuser,
    input logic                           m_axis_tlast
);

    // hold a stalled word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    // a failed request ends its run with a zero value
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != deq_pkg::ST_OK)
        |-> m_axis_tlast && (m_axis_tdata[deq_pkg::VALUE_W-1:0] == '0))
        else $error("failed request with data or without last");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == deq_pkg::ST_FULL)
        |-> m_axis_tdata[deq_pkg::VALUE_W +: deq_pkg::COUNT_W]
            == deq_pkg::COUNT_W'(deq_pkg::DEPTH))
        else $error("full status with queue not full");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == deq_pkg::ST_EMPTY)
        |-> m_axis_tdata[deq_pkg::VALUE_W +: deq_pkg::COUNT_W] == '0)
        else $error("empty status with queue not empty");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid
        |-> m_axis_tdata[deq_pkg::VALUE_W +: deq_pkg::COUNT_W]
            <= deq_pkg::COUNT_W'(deq_pkg::DEPTH))
        else $error("count above depth");

endmodule

bind double_ended_queue deq_chk u_deq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/deq_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deq_checker
// Watches both stream channels of the double-ended queue. Keeps a local copy
// of the queue, derives the result words of every accepted request and
// compares each delivered word, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module deq_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // [2:0] op, [34:3] push_value, [39:35] zero
    input  logic [deq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] item_value, [37:32] item_count, [39:38] zero
    input  logic [deq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [1:0] status
    input  logic [deq_pkg::STATUS_W-1:0]   m_axis_tuser,
    input  logic                           m_axis_tlast,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked
);
    import deq_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_status            status;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_deq_word;

    t_deq_word         due_words[$];
    logic [DATA_W-1:0] ring_copy [DEPTH];
    int unsigned       head_pos;
    int unsigned       fill_level;

    function automatic int unsigned ring_pos(input int unsigned offset);
        return (head_pos + offset) % DEPTH;
    endfunction

    task automatic queue_word(input logic [VALUE_W-1:0] value, input t_status status,
                              input logic last);
        t_deq_word w;
        w.value  = value;
        w.status = status;
        w.count  = COUNT_W'(fill_level);
        w.last   = last;
        due_words.push_back(w);
    endtask

    task automatic predict_request(input logic [S_TDATA_W-1:0] word);
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] push_value;
        logic [DATA_W-1:0]  got;
        op         = word[OP_W-1:0];
        push_value = word[OP_W +: VALUE_W];
        case (op)
            OP_PUSH_REAR, OP_PUSH_FRONT: begin
                if (fill_level >= DEPTH) begin
                    queue_word('0, ST_FULL, 1'b1);
                end else begin
                    if (op == OP_PUSH_FRONT) begin
                        head_pos = ring_pos(DEPTH - 1);
                        ring_copy[head_pos] = DATA_W'(push_value);
                    end else begin
                        ring_copy[ring_pos(fill_level)] = DATA_W'(push_value);
                    end
                    fill_level++;
                    queue_word('0, ST_OK, 1'b1);
                end
            end
            OP_POP_REAR, OP_POP_FRONT: begin
                if (fill_level == 0) begin
                    queue_word('0, ST_EMPTY, 1'b1);
                end else begin
                    if (op == OP_POP_FRONT) begin
                        got = ring_copy[head_pos];
                        head_pos = ring_pos(1);
                    end else begin
                        got = ring_copy[ring_pos(fill_level - 1)];
                    end
                    fill_level--;
                    queue_word(VALUE_W'(got), ST_OK, 1'b1);
                end
            end
            OP_LIST: begin
                if (fill_level == 0) begin
                    queue_word('0, ST_EMPTY, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < fill_level; i++) begin
                        queue_word(VALUE_W'(ring_copy[ring_pos(i)]), ST_OK,
                                   i == fill_level - 1);
                    end
                end
            end
            default: begin
                // reserved codes: drop the request, no word comes back
            end
        endcase
    endtask

    task automatic report(input string field, input longint want, input longint seen);
        o_errors++;
        $display("%0t: %s expected %0h, got %0h", $time, field, want, seen);
    endtask

    task automatic check_word();
        t_deq_word          want;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        value = m_axis_tdata[VALUE_W-1:0];
        count = m_axis_tdata[VALUE_W +: COUNT_W];
        if (due_words.size() == 0) begin
            o_errors++;
            $display("%0t: expected no word, got value %0h status %0d count %0d last %b",
                     $time, value, m_axis_tuser, count, m_axis_tlast);
        end else begin
            want = due_words.pop_front();
            o_checked++;
            if (value !== want.value) report("item_value", want.value, value);
            if (m_axis_tuser !== want.status) report("status", want.status, m_axis_tuser);
            if (count !== want.count) report("item_count", want.count, count);
            if (m_axis_tlast !== want.last) report("last", want.last, m_axis_tlast);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            due_words.delete();
            head_pos   = 0;
            fill_level = 0;
        end else begin
            // predict first: a request never answers in its own cycle
            if (s_axis_tvalid && s_axis_tready) predict_request(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) check_word();
        end
        o_pending = due_words.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the double-ended queue with random gaps and output
// stalls: empty and wrap corner cases first, then fill, mixed, drain and
// steady phases with random values. The checker beside the block judges
// every result word; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import deq_pkg::*;

    localparam int ITEM_GOAL    = 430;
    localparam int PHASE_LEN    = 45;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 16;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]  m_axis_tuser;
    logic                 m_axis_tlast;

    int err_count;
    int pending_count;
    int checked_count;
    int requests;
    int pushes;
    int pops;
    int listings;
    int reserved;
    bit tx_steady;
    bit rx_steady;
    bit long_hold_req;

    double_ended_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    deq_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_errors      (err_count),
        .o_pending     (pending_count),
        .o_checked     (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        if ($urandom_range(0, 9) != 0) return $urandom();
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return OP_W'(int'(OP_LIST) + $urandom_range(1, 3));
        if (r < 9) return OP_LIST;
        if ($urandom_range(0, 99) < push_pct) begin
            return $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        end
        return $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
    endfunction

    // call at a falling edge; returns at the falling edge after the accept
    task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
        int gap;
        gap = 0;
        if (!tx_steady && $urandom_range(0, 2) == 0) gap = idle_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = S_TDATA_W'({value, op});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        case (op)
            OP_PUSH_REAR, OP_PUSH_FRONT: pushes++;
            OP_POP_REAR, OP_POP_FRONT:   pops++;
            OP_LIST:                     listings++;
            default:                     reserved++;
        endcase
        if (op <= OP_LIST) requests++;
    endtask

    // output side: random stalls, one long hold on request
    initial begin
        int stall_left;
        bit hold_done;
        stall_left    = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !hold_done) begin
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (rx_steady) begin
                m_axis_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                m_axis_tready = 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = idle_gap();
            end
        end
    end

    initial begin
        logic [OP_W-1:0] op;
        int              phase;
        int              push_pct;
        int              n;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        long_hold_req = 1'b0;
        requests      = 0;
        pushes        = 0;
        pops          = 0;
        listings      = 0;
        reserved      = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty queue: pops and listing report empty
        send_request(OP_POP_REAR, '0);
        send_request(OP_POP_FRONT, 32'hFFFF_FFFF);
        send_request(OP_LIST, '0);
        // value extremes at both ends, front push wraps the ring
        send_request(OP_PUSH_REAR, 32'h7FFF_FFFF);
        send_request(OP_PUSH_FRONT, 32'h8000_0000);
        send_request(OP_PUSH_REAR, 32'hFFFF_FFFF);
        send_request(OP_PUSH_FRONT, 32'h0000_0000);
        send_request(OP_LIST, 32'hFFFF_FFFF);
        send_request(OP_POP_FRONT, 32'hA5A5_A5A5);
        send_request(OP_POP_REAR, '0);
        for (int code = int'(OP_LIST) + 1; code < (1 << OP_W); code++) begin
            send_request(OP_W'(code), rand_value());
        end
        send_request(OP_LIST, '0);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_POP_REAR, '0);
        send_request(OP_POP_REAR, '0);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_LIST, '0);

        // fill, mixed, drain and steady phases in turn
        phase = 0;
        while (requests < ITEM_GOAL) begin
            case (phase % 4)
                0: push_pct = 90;
                1: begin
                    push_pct = 50;
                    // hold the output off once while requests keep coming
                    if (phase == 1) long_hold_req = 1'b1;
                end
                2: push_pct = 10;
                default: begin
                    push_pct  = 60;
                    tx_steady = 1'b1;
                    rx_steady = 1'b1;
                end
            endcase
            n = 0;
            while (n < PHASE_LEN && requests < ITEM_GOAL) begin
                op = pick_op(push_pct);
                send_request(op, rand_value());
                if (op <= OP_LIST) n++;
            end
            tx_steady = 1'b0;
            rx_steady = 1'b0;
            phase++;
        end
        s_axis_tvalid = 1'b0;

        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d requests: %0d pushes, %0d pops, %0d listings, %0d reserved codes,",
                 requests, pushes, pops, listings, reserved);
        $display("through fill, drain, steady and long-stall phases; %0d result words checked.",
                 checked_count);
        if (err_count == 0 && pending_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("testbench: errors");
        $finish;
    end

endmodule
